@@ rtl/boo_pkg.sv @@
package boo_pkg;

  // Geometry of the overlay window and the box list
  localparam int MaxBoxes   = 8;
  localparam int WinW       = 640;
  localparam int WinH       = 480;

  // Count pips: 12x12 squares along the top of the window
  localparam int PipOrigin  = 8;
  localparam int PipPitch   = 18;
  localparam int PipSize    = 12;

  // Coordinate arithmetic width, wide enough for start + length sums
  localparam int CoordW     = 12;
  // Raw placement values before clamping
  localparam int RawW       = 11;
  // Product width of a Q0.16 (plus carry bit) value times a window dimension
  localparam int ProdW      = 28;

  // Configuration port
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;

  localparam logic [CfgIdxW-1:0] RegBoxColor  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLineThick = 2'd1;

  localparam logic [15:0] BoxColorRst  = 16'hF0F0;
  localparam logic [3:0]  LineThickRst = 4'd3;
  localparam logic [15:0] Transparent  = 16'h0000;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpQuery = 2'd2,
    OpRsvd  = 2'd3
  } op_e;

  // Command presented to the placement front end
  typedef struct packed {
    op_e         op;
    logic [16:0] center_x;
    logic [16:0] center_y;
    logic [16:0] size_x;
    logic [16:0] size_y;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
  } req_t;

  // Token that walks the chain of box cells
  typedef struct packed {
    op_e         op;
    logic [9:0]  px;
    logic [8:0]  py;
    logic        in_win;
    logic        hit;
    logic [9:0]  box_x;
    logic [8:0]  box_y;
    logic [10:0] box_w;
    logic [9:0]  box_h;
  } tok_t;

endpackage

@@ rtl/boo_if.sv @@
// Command channel
interface boo_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [16:0] center_x;
  logic [16:0] center_y;
  logic [16:0] size_x;
  logic [16:0] size_y;
  logic [9:0]  pixel_x;
  logic [8:0]  pixel_y;

  modport source (
    output valid, opcode, center_x, center_y, size_x, size_y, pixel_x, pixel_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, center_x, center_y, size_x, size_y, pixel_x, pixel_y,
    output ready
  );
endinterface

// Pixel result channel
interface boo_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_color;

  modport source (output valid, pixel_color, input ready);
  modport sink   (input valid, pixel_color, output ready);
endinterface

@@ rtl/boo_place.sv @@
module boo_place (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3:0]    thick_i,
  input  logic          vld_i,
  input  boo_pkg::req_t req_i,
  output logic          vld_o,
  output boo_pkg::tok_t tok_o
);
  import boo_pkg::*;

  typedef struct packed {
    op_e              op;
    logic [9:0]       px;
    logic [8:0]       py;
    logic             in_win;
    logic [RawW-1:0]  len_x;
    logic [RawW-1:0]  st_x;
    logic [RawW-1:0]  len_y;
    logic [RawW-1:0]  st_y;
  } s1_t;

  s1_t  s1_d, s1_q;
  logic s1_vld_q;
  tok_t tok_d, tok_q;
  logic tok_vld_q;

  logic [ProdW-1:0] prod_lx, prod_ly, prod_sx, prod_sy;
  logic [17:0]      twice_x, twice_y, diff_x, diff_y;

  // Stage 1: scale size and corner offset by the window dimension
  always_comb begin
    twice_x = {req_i.center_x, 1'b0};
    twice_y = {req_i.center_y, 1'b0};
    diff_x  = twice_x - {1'b0, req_i.size_x};
    diff_y  = twice_y - {1'b0, req_i.size_y};
    prod_lx = ProdW'(req_i.size_x) * ProdW'(WinW);
    prod_ly = ProdW'(req_i.size_y) * ProdW'(WinH);
    prod_sx = ProdW'(diff_x) * ProdW'(WinW);
    prod_sy = ProdW'(diff_y) * ProdW'(WinH);

    s1_d.op     = req_i.op;
    s1_d.px     = req_i.pixel_x;
    s1_d.py     = req_i.pixel_y;
    s1_d.in_win = (req_i.pixel_x < 10'(WinW)) && (req_i.pixel_y < 9'(WinH));
    s1_d.len_x  = RawW'(prod_lx >> 16);
    s1_d.len_y  = RawW'(prod_ly >> 16);
    s1_d.st_x   = (twice_x > {1'b0, req_i.size_x}) ? RawW'(prod_sx >> 17) : '0;
    s1_d.st_y   = (twice_y > {1'b0, req_i.size_y}) ? RawW'(prod_sy >> 17) : '0;
  end

  // Stage 2: minimum size, saturate start, cut length to the window
  logic [RawW-1:0] two_t, lx, ly, sx, sy;

  always_comb begin
    two_t = RawW'({thick_i, 1'b0});
    lx = (s1_q.len_x < two_t) ? two_t : s1_q.len_x;
    ly = (s1_q.len_y < two_t) ? two_t : s1_q.len_y;
    sx = (s1_q.st_x > RawW'(WinW)) ? RawW'(WinW) : s1_q.st_x;
    sy = (s1_q.st_y > RawW'(WinH)) ? RawW'(WinH) : s1_q.st_y;
    if ((CoordW'(sx) + CoordW'(lx)) > CoordW'(WinW)) begin
      lx = RawW'(WinW) - sx;
    end
    if ((CoordW'(sy) + CoordW'(ly)) > CoordW'(WinH)) begin
      ly = RawW'(WinH) - sy;
    end

    tok_d.op     = s1_q.op;
    tok_d.px     = s1_q.px;
    tok_d.py     = s1_q.py;
    tok_d.in_win = s1_q.in_win;
    tok_d.hit    = 1'b0;
    tok_d.box_x  = 10'(sx);
    tok_d.box_y  = 9'(sy);
    tok_d.box_w  = 11'(lx);
    tok_d.box_h  = 10'(ly);
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      tok_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q  <= vld_i;
      tok_vld_q <= s1_vld_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q  <= s1_d;
      tok_q <= tok_d;
    end
  end

  assign vld_o = tok_vld_q;
  assign tok_o = tok_q;

endmodule

@@ rtl/boo_cell.sv @@
module boo_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [3:0]                  thick_i,
  input  logic [boo_pkg::CoordW-1:0]  pip_x_i,
  input  logic                        vld_i,
  input  boo_pkg::tok_t               tok_i,
  output logic                        vld_o,
  output boo_pkg::tok_t               tok_o,
  output logic                        box_vld_o
);
  import boo_pkg::*;

  logic        box_vld_q, box_vld_d;
  logic [9:0]  x_q;
  logic [8:0]  y_q;
  logic [10:0] w_q;
  logic [9:0]  h_q;
  logic        store;

  tok_t tok_d, tok_q;
  logic vld_d, vld_q;

  logic [CoordW-1:0] px, py, t, x0, x1, y0, y1;
  logic              in_x, in_y, top, bot, lft, rgt, pip;

  // Outline and pip test against the box held here
  always_comb begin
    px = CoordW'(tok_i.px);
    py = CoordW'(tok_i.py);
    t  = CoordW'(thick_i);
    x0 = CoordW'(x_q);
    y0 = CoordW'(y_q);
    x1 = x0 + CoordW'(w_q);
    y1 = y0 + CoordW'(h_q);

    in_x = (px >= x0) && (px < x1);
    in_y = (py >= y0) && (py < y1);
    top  = in_x && (py >= y0) && (py < y0 + t);
    bot  = in_x && (py + t >= y1) && (py < y1);
    lft  = in_y && (px >= x0) && (px < x0 + t);
    rgt  = in_y && (px + t >= x1) && (px < x1);
    pip  = (px >= pip_x_i) && (px < pip_x_i + CoordW'(PipSize)) &&
           (py >= CoordW'(PipOrigin)) && (py < CoordW'(PipOrigin + PipSize));
  end

  // Token update: clear empties, first empty cell takes an add, query ORs hit
  always_comb begin
    tok_d     = tok_i;
    vld_d     = vld_i;
    box_vld_d = box_vld_q;
    store     = 1'b0;
    if (vld_i) begin
      case (tok_i.op)
        OpClear: box_vld_d = 1'b0;
        OpAdd: begin
          if (!box_vld_q) begin
            store     = 1'b1;
            box_vld_d = 1'b1;
            vld_d     = 1'b0;
          end
        end
        OpQuery: begin
          if (box_vld_q && tok_i.in_win && (top || bot || lft || rgt || pip)) begin
            tok_d.hit = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_vld_q <= 1'b0;
      vld_q     <= 1'b0;
    end else if (en_i) begin
      box_vld_q <= box_vld_d;
      vld_q     <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok_q <= tok_d;
      if (store) begin
        x_q <= tok_i.box_x;
        y_q <= tok_i.box_y;
        w_q <= tok_i.box_w;
        h_q <= tok_i.box_h;
      end
    end
  end

  assign vld_o     = vld_q;
  assign tok_o     = tok_q;
  assign box_vld_o = box_vld_q;

endmodule

@@ rtl/box_outline_overlay.sv @@
// Box outline overlay. Commands (clear list, add box, query pixel) are taken
// one per clock and flow in order through a two-stage placement front end and
// then a chain of one cell per box slot (eight by default); each cell holds one
// placed box and tests every passing pixel query against its outline and its
// count pip. A query result is registered after the placement stages and all cells,
// and throughput is one command per cycle, limited only by backpressure on the
// result channel, which stalls the whole chain. Clears and adds give no result;
// an add with the list full is dropped. No clearing pass is needed after reset.
module box_outline_overlay (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  boo_in_if.sink                        in_i,
  boo_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [boo_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [boo_pkg::CfgDataW-1:0]  cfg_data_i
);
  import boo_pkg::*;

  logic [15:0] color_q;
  logic [3:0]  thick_q;
  logic        en;
  req_t        req;

  tok_t                chain_tok [MaxBoxes+1];
  logic [MaxBoxes:0]   chain_vld;
  logic [MaxBoxes-1:0] cell_vld;

  logic        out_vld_q;
  logic [15:0] out_data_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= BoxColorRst;
      thick_q <= LineThickRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegBoxColor:  color_q <= cfg_data_i;
        RegLineThick: thick_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Whole pipeline advances unless a result waits on a stalled sink
  assign en         = !(out_vld_q && !out_o.ready);
  assign in_i.ready = en;

  always_comb begin
    req.op       = op_e'(in_i.opcode);
    req.center_x = in_i.center_x;
    req.center_y = in_i.center_y;
    req.size_x   = in_i.size_x;
    req.size_y   = in_i.size_y;
    req.pixel_x  = in_i.pixel_x;
    req.pixel_y  = in_i.pixel_y;
  end

  boo_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .thick_i (thick_q),
    .vld_i   (in_i.valid),
    .req_i   (req),
    .vld_o   (chain_vld[0]),
    .tok_o   (chain_tok[0])
  );

  // Chain of box cells
  for (genvar g = 0; g < MaxBoxes; g++) begin : g_cell
    boo_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .thick_i   (thick_q),
      .pip_x_i   (CoordW'(PipOrigin + g * PipPitch)),
      .vld_i     (chain_vld[g]),
      .tok_i     (chain_tok[g]),
      .vld_o     (chain_vld[g+1]),
      .tok_o     (chain_tok[g+1]),
      .box_vld_o (cell_vld[g])
    );
  end

  // Result register: only queries leave the chain as a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= chain_vld[MaxBoxes] && (chain_tok[MaxBoxes].op == OpQuery);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= chain_tok[MaxBoxes].hit ? color_q : Transparent;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.pixel_color = out_data_q;

  // A waiting result holds its value until it transfers
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.pixel_color)))
    else $error("result changed while waiting");

  // A stalled result freezes the chain
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready) |=> ($stable(chain_vld) && $stable(cell_vld)))
    else $error("chain moved during result stall");

  // A new result comes only from a query leaving the chain
  a_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(chain_vld[MaxBoxes] &&
                               (chain_tok[MaxBoxes].op == OpQuery)))
    else $error("result without a query");

endmodule
